// ===== src/skl_pkg.sv =====
package skl_pkg;

  // Default sizes of the key store.
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields.
  localparam int REQ_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int IDX_W    = 6;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;

  // Request codes.
  localparam logic [REQ_W-1:0] OP_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] OP_GET    = 2'd1;
  localparam logic [REQ_W-1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOB  = 2'd2;

  // Control part of the wave that walks from cell to cell.
  typedef struct packed {
    logic             act;
    logic [REQ_W-1:0] op;
    logic             placed;
    logic             carry;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
  } wave_t;

endpackage

// ===== src/skl_if.sv =====
interface skl_req_if;
  logic                          valid;
  logic                          ready;
  logic [skl_pkg::REQ_W-1:0]     req_type;
  logic [skl_pkg::KEY_IN_W-1:0]  key;
  logic [skl_pkg::IDX_W-1:0]     index;

  modport source (output valid, req_type, key, index, input ready);
  modport sink (input valid, req_type, key, index, output ready);
endinterface

interface skl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [skl_pkg::STAT_W-1:0]    status;
  logic [skl_pkg::KEY_IN_W-1:0]  key_out;
  logic                          found;
  logic [skl_pkg::POS_W-1:0]     position;
  logic [skl_pkg::CNT_W-1:0]     count;

  modport source (output valid, status, key_out, found, position, count, input ready);
  modport sink (input valid, status, key_out, found, position, count, output ready);
endinterface

// ===== src/skl_cell.sv =====
module skl_cell #(
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEF,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 order_mode,
  input  skl_pkg::wave_t       wave_in,
  input  logic [KEY_WIDTH-1:0] data_in,
  input  logic [KEY_WIDTH-1:0] nbr_entry,
  input  logic                 nbr_occ,
  output skl_pkg::wave_t       wave_out,
  output logic [KEY_WIDTH-1:0] data_out,
  output logic [KEY_WIDTH-1:0] entry,
  output logic                 occ
);

  localparam int PW = skl_pkg::POS_W;
  localparam logic [PW-1:0] POS_C = PW'(INDEX);

  logic [KEY_WIDTH-1:0] entry_next;
  logic                 occ_next;
  skl_pkg::wave_t       wave_next;
  logic [KEY_WIDTH-1:0] data_next;
  logic                 goes_after;

  // The new key belongs after this entry in the current order.
  assign goes_after = order_mode ? (data_in < entry) : (data_in > entry);

  always_comb begin
    entry_next = entry;
    occ_next   = occ;
    wave_next  = wave_in;
    data_next  = data_in;
    if (wave_in.act) begin
      unique case (wave_in.op)
        skl_pkg::OP_INSERT: begin
          if (!wave_in.placed) begin
            if (!occ || !goes_after) begin
              entry_next       = data_in;
              occ_next         = 1'b1;
              wave_next.placed = 1'b1;
              wave_next.carry  = occ;
              wave_next.pos    = POS_C;
              data_next        = entry;
            end
          end else if (wave_in.carry) begin
            // Shift the displaced key up by one place.
            entry_next      = data_in;
            occ_next        = 1'b1;
            wave_next.carry = occ;
            data_next       = entry;
          end
        end
        skl_pkg::OP_GET: begin
          if (INDEX == int'(wave_in.idx)) begin
            data_next = entry;
          end
        end
        skl_pkg::OP_REMOVE: begin
          // The upper neighbor is not yet touched by the wave this cycle.
          if (INDEX >= int'(wave_in.idx)) begin
            entry_next = nbr_entry;
            occ_next   = nbr_occ;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= 1'b0;
      wave_out.act <= 1'b0;
    end else begin
      occ          <= occ_next;
      wave_out.act <= wave_next.act;
    end
    entry           <= entry_next;
    data_out        <= data_next;
    wave_out.op     <= wave_next.op;
    wave_out.placed <= wave_next.placed;
    wave_out.carry  <= wave_next.carry;
    wave_out.idx    <= wave_next.idx;
    wave_out.pos    <= wave_next.pos;
  end

endmodule

// ===== src/sorted_key_list_unit.sv =====
// An insert into a list with room, and a get or remove with an index below the count, launches
// a wave that crosses all DEPTH cells one per cycle; its result is registered when the wave leaves
// the last cell, and no new request is taken while it is in flight. Every other request is answered
// in the response register directly, one per cycle while the response side takes each response.
// Reset (rst, synchronous, active high) empties the list, clears order_mode and drops any
// pending response; the key registers themselves keep stale data that is never read.
module sorted_key_list_unit #(
  parameter int DEPTH     = skl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  skl_req_if.sink   req,
  skl_rsp_if.source rsp
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW_IN = skl_pkg::KEY_IN_W;
  localparam int CNTW  = skl_pkg::CNT_W;

  // Control states: idle accepts requests, busy waits for the wave to leave the last cell.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                 state;
  logic [CW-1:0]        count;
  logic                 order_mode;

  // Wave signals between neighboring cells; index 0 is the launch register,
  // index DEPTH is what leaves the last cell.
  skl_pkg::wave_t       wave_c [DEPTH+1];
  logic [KEY_WIDTH-1:0] data_c [DEPTH+1];
  logic [KEY_WIDTH-1:0] entry_c [DEPTH];
  logic                 occ_c [DEPTH];
  logic [KEY_WIDTH-1:0] nbr_e [DEPTH];
  logic                 nbr_o [DEPTH];

  logic                 accept;
  logic                 full;
  logic                 in_range;
  logic                 tail;
  logic                 launch;
  logic                 answer_now;

  logic                       rsp_valid;
  logic [skl_pkg::STAT_W-1:0] rsp_status;
  logic [KW_IN-1:0]           rsp_key;
  logic                       rsp_found;
  logic [skl_pkg::POS_W-1:0]  rsp_pos;
  logic [CNTW-1:0]            rsp_count;

  // A new request is taken when no wave is in flight and the response
  // register is empty or being emptied in the same cycle.
  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign in_range  = (32'(req.index) < 32'(count));
  assign tail      = wave_c[DEPTH].act;

  // An insert with room, or a get or remove inside the list, sends a wave down
  // the row; every other accepted request is answered right away.
  assign launch     = accept &&
                      (((req.req_type == skl_pkg::OP_INSERT) && !full) ||
                       (((req.req_type == skl_pkg::OP_GET) ||
                         (req.req_type == skl_pkg::OP_REMOVE)) && in_range));
  assign answer_now = accept && !launch;

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.key_out  = rsp_key;
  assign rsp.found    = rsp_found;
  assign rsp.position = rsp_pos;
  assign rsp.count    = rsp_count;

  // Row of cells. Each cell holds one key and its occupied flag. The wave moves
  // up one cell per cycle; a remove pulls the key of the upper neighbor down.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign nbr_e[i] = '0;
      assign nbr_o[i] = 1'b0;
    end else begin : g_mid
      assign nbr_e[i] = entry_c[i+1];
      assign nbr_o[i] = occ_c[i+1];
    end

    skl_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .order_mode (order_mode),
      .wave_in    (wave_c[i]),
      .data_in    (data_c[i]),
      .nbr_entry  (nbr_e[i]),
      .nbr_occ    (nbr_o[i]),
      .wave_out   (wave_c[i+1]),
      .data_out   (data_c[i+1]),
      .entry      (entry_c[i]),
      .occ        (occ_c[i])
    );
  end

  // Control: checks bounds against the count, launches the wave, and loads the
  // response register either at once or when the wave leaves the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      order_mode    <= 1'b0;
      rsp_valid     <= 1'b0;
      wave_c[0].act <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_mode <= cfg_wr_data;
      end
      wave_c[0].act <= launch;
      // The response register fills from an immediate answer or from the wave
      // leaving the row, and empties when its transaction is taken.
      if (answer_now || tail) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wave_c[0].op     <= req.req_type;
            wave_c[0].placed <= 1'b0;
            wave_c[0].carry  <= 1'b0;
            wave_c[0].idx    <= req.index;
            wave_c[0].pos    <= '0;
            data_c[0]        <= (req.req_type == skl_pkg::OP_INSERT) ?
                                KEY_WIDTH'(req.key) : '0;
            rsp_key          <= '0;
            rsp_found        <= 1'b0;
            rsp_pos          <= '0;
            rsp_count        <= CNTW'(count);
            case (req.req_type)
              skl_pkg::OP_INSERT: begin
                if (full) begin
                  rsp_status <= skl_pkg::ST_FULL;
                end else begin
                  count <= count + 1'b1;
                  state <= ST_BUSY;
                end
              end
              skl_pkg::OP_GET: begin
                if (in_range) begin
                  state <= ST_BUSY;
                end else begin
                  rsp_status <= skl_pkg::ST_OOB;
                end
              end
              skl_pkg::OP_REMOVE: begin
                if (in_range) begin
                  count <= count - 1'b1;
                  state <= ST_BUSY;
                end else begin
                  rsp_status <= skl_pkg::ST_OOB;
                end
              end
              default: begin
                // An unused request code answers success and changes nothing.
                rsp_status <= skl_pkg::ST_OK;
              end
            endcase
          end
        end
        ST_BUSY: begin
          if (tail) begin
            // The response register is known to be empty while the wave runs.
            rsp_status <= skl_pkg::ST_OK;
            rsp_found  <= (wave_c[DEPTH].op == skl_pkg::OP_GET);
            rsp_key    <= (wave_c[DEPTH].op == skl_pkg::OP_GET) ?
                          KW_IN'(data_c[DEPTH]) : '0;
            rsp_pos    <= (wave_c[DEPTH].op == skl_pkg::OP_INSERT) ?
                          wave_c[DEPTH].pos : '0;
            rsp_count  <= CNTW'(count);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/skl_checker.sv =====
module skl_checker #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [skl_pkg::STAT_W-1:0] status,
  input logic [skl_pkg::KEY_IN_W-1:0] key_out,
  input logic                       found,
  input logic [skl_pkg::POS_W-1:0]  position,
  input logic [skl_pkg::CNT_W-1:0]  count
);

  localparam int CNTW = skl_pkg::CNT_W;

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> status == skl_pkg::ST_OK && position == '0)
    else $error("found set on a response that is not a successful get");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == skl_pkg::ST_FULL |-> count == CNTW'(DEPTH) && !found)
    else $error("full status reported with room left in the list");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> key_out == '0)
    else $error("key_out nonzero without a found key");

  a_oob_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == skl_pkg::ST_OOB |-> position == '0 && !found)
    else $error("out of bounds response carries a position or a key");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(key_out)
      && $stable(count))
    else $error("stalled response transaction changed");

endmodule

bind sorted_key_list_unit skl_checker #(.DEPTH(DEPTH)) u_skl_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .key_out   (rsp.key_out),
  .found     (rsp.found),
  .position  (rsp.position),
  .count     (rsp.count)
);

// ===== dv/skl_tb_pkg.sv =====
`timescale 1ns / 1ps

package skl_tb_pkg;
  import skl_pkg::*;

  // Request code that the block must answer without touching the list.
  localparam logic [REQ_W-1:0] OP_UNUSED = 2'd3;

  // Values of the order_mode register.
  localparam bit ORDER_ASC  = 1'b0;
  localparam bit ORDER_DESC = 1'b1;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [KEY_IN_W-1:0] key_out;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    count;
  } skl_result_t;

  // Mirror of the sorted list plus the queue of responses still owed by the block.
  class skl_scoreboard;
    logic [KEY_IN_W-1:0] keys [DEPTH_DEF];
    int unsigned         stored;
    bit                  descending;
    skl_result_t         awaited [$];
    int unsigned errors, checked, peak;
    int unsigned n_insert, n_full, n_get, n_remove, n_oob, n_unused, n_order_writes;

    function new();
      stored = 0;
      descending = ORDER_ASC;
      errors = 0;
      checked = 0;
      peak = 0;
      n_insert = 0;
      n_full = 0;
      n_get = 0;
      n_remove = 0;
      n_oob = 0;
      n_unused = 0;
      n_order_writes = 0;
    endfunction

    function void set_order(bit mode);
      descending = mode;
      n_order_writes++;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function logic [KEY_IN_W-1:0] key_at(int unsigned slot);
      return keys[slot];
    endfunction

    // True when key a sorts after key b under the current order.
    function bit sorts_after(logic [KEY_IN_W-1:0] a, logic [KEY_IN_W-1:0] b);
      return descending ? (a < b) : (a > b);
    endfunction

    function void note_request(logic [REQ_W-1:0] op, logic [KEY_IN_W-1:0] key,
                               logic [IDX_W-1:0] idx);
      skl_result_t want;
      int unsigned slot;
      want = '0;
      case (op)
        OP_INSERT: begin
          n_insert++;
          if (stored >= DEPTH_DEF) begin
            want.status = ST_FULL;
            n_full++;
          end else begin
            // Lower bound: first stored key that the new key does not sort after.
            slot = stored;
            for (int i = 0; i < stored; i++) begin
              if (slot == stored && !sorts_after(key, keys[i])) slot = i;
            end
            for (int i = stored; i > slot; i--) keys[i] = keys[i-1];
            keys[slot] = key;
            stored++;
            want.position = POS_W'(slot);
          end
        end
        OP_GET: begin
          n_get++;
          if (idx < stored) begin
            want.key_out = keys[idx];
            want.found = 1'b1;
          end else begin
            want.status = ST_OOB;
            n_oob++;
          end
        end
        OP_REMOVE: begin
          n_remove++;
          if (idx < stored) begin
            for (int i = idx; i + 1 < stored; i++) keys[i] = keys[i+1];
            stored--;
          end else begin
            want.status = ST_OOB;
            n_oob++;
          end
        end
        default: begin
          n_unused++;
        end
      endcase
      want.count = CNT_W'(stored);
      if (stored > peak) peak = stored;
      awaited.push_back(want);
    endfunction

    function void compare_field(string name, logic [KEY_IN_W-1:0] want,
                                logic [KEY_IN_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(skl_result_t got);
      skl_result_t want;
      if (awaited.size() == 0) begin
        $error("response with no request outstanding: status %0d count %0d",
               got.status, got.count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("key_out", want.key_out, got.key_out);
      compare_field("found", want.found, got.found);
      compare_field("position", want.position, got.position);
      compare_field("count", want.count, got.count);
    endfunction
  endclass

endpackage

// ===== dv/tb_sorted_key_list_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_list_unit;
  import skl_pkg::*;
  import skl_tb_pkg::*;

  // The long response hold used to back the block up; it is far longer than one
  // walk across the cell row, so the next request waits behind the held response.
  localparam int unsigned RSP_HOLD_CYCLES = 300;

  // Tail after the last response: one full walk of the wave plus a margin, so a
  // stray extra response would still be seen.
  localparam int unsigned TAIL_CYCLES = DEPTH_DEF + 8;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  skl_req_if req_ch ();
  skl_rsp_if rsp_ch ();

  sorted_key_list_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  skl_scoreboard sb = new();

  // When quiet is set, neither side inserts idle cycles. The stimulus process
  // raises rsp_hold_req to ask the response side for one long hold.
  bit          quiet = 1'b0;
  bit          rsp_hold_req = 1'b0;
  int unsigned rsp_holds_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: none when quiet is set; else mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request transaction and returns once it has been accepted. The
  // mirror is updated at the accepting edge, so it always holds the list state
  // that the next request will see inside the block.
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [KEY_IN_W-1:0] key,
                          input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = op;
    req_ch.key      = key;
    req_ch.index    = idx;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, key, idx);
  endtask

  // Stops offering requests and waits for every owed response. The block has no
  // request that goes unanswered, so an empty queue means it is idle.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // The order register is only written while the block is idle.
  task automatic write_order(input bit mode);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_order(mode);
  endtask

  // Hand-picked requests: empty list, unused code, extreme keys, duplicates,
  // indexes at and past the count, and an order flip with keys still stored.
  task automatic run_directed();
    write_order(ORDER_ASC);
    send_req(OP_GET, '0, '0);
    send_req(OP_REMOVE, '1, 6'd63);
    send_req(OP_UNUSED, '1, 6'd63);
    send_req(OP_INSERT, 32'd5, 6'd0);
    send_req(OP_INSERT, 32'd0, 6'd63);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_INSERT, 32'd5, 6'd0);
    send_req(OP_INSERT, 32'd5, 6'd0);
    send_req(OP_GET, '0, 6'd0);
    send_req(OP_GET, '0, 6'd1);
    send_req(OP_GET, '0, 6'd5);
    send_req(OP_GET, '0, 6'd6);
    send_req(OP_REMOVE, '0, 6'd1);
    send_req(OP_REMOVE, '0, 6'd3);
    send_req(OP_GET, '0, 6'd63);
    send_req(OP_INSERT, 32'h8000_0000, 6'd0);
    // Keys stay in ascending order while the mode says descending from here on.
    write_order(ORDER_DESC);
    send_req(OP_INSERT, 32'd7, 6'd0);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_INSERT, 32'd0, 6'd0);
    send_req(OP_GET, '0, 6'd0);
    send_req(OP_UNUSED, '0, '0);
  endtask

  // One phase of random traffic. The mix sets how often each operation is
  // picked; most indexes fall inside the list so that gets and removes do real
  // work, and some keys repeat stored ones or sit at the ends of the range.
  task automatic run_traffic(input bit mode, input traffic_mix_t mix,
                             input int unsigned items, input bit hold_rsp);
    int unsigned r;
    int unsigned n;
    logic [REQ_W-1:0]    op;
    logic [KEY_IN_W-1:0] key;
    logic [IDX_W-1:0]    idx;
    write_order(mode);
    if (hold_rsp) rsp_hold_req = 1'b1;
    for (n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  op = (r < 88) ? OP_INSERT : (r < 96) ? OP_GET :
                        (r < 98) ? OP_REMOVE : OP_UNUSED;
        MIX_DRAIN: op = (r < 78) ? OP_REMOVE : (r < 90) ? OP_GET :
                        (r < 97) ? OP_INSERT : OP_UNUSED;
        default:   op = (r < 40) ? OP_INSERT : (r < 68) ? OP_GET :
                        (r < 94) ? OP_REMOVE : OP_UNUSED;
      endcase
      r = $urandom_range(0, 99);
      if (r < 45)      key = $urandom;
      else if (r < 70) key = $urandom_range(0, 15);
      else if (r < 80) key = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else if (r < 88) key = '0;
      else if (sb.stored != 0) key = sb.key_at($urandom_range(0, sb.stored - 1));
      else             key = $urandom;
      if (sb.stored != 0 && $urandom_range(0, 99) < 80)
        idx = $urandom_range(0, sb.stored - 1);
      else
        idx = $urandom_range(0, 63);
      send_req(op, key, idx);
    end
  endtask

  // Response side ready: random stalls, plus one long hold on request.
  initial begin : rsp_ready_drive
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_ch.ready = 1'b0;
        repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
        rsp_hold_req = 1'b0;
        rsp_holds_done++;
      end else if (rst) begin
        rsp_ch.ready = 1'b0;
      end else if (stall_left != 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Every response transaction is checked against the oldest owed result.
  always @(posedge clk) begin
    skl_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status   = rsp_ch.status;
      got.key_out  = rsp_ch.key_out;
      got.found    = rsp_ch.found;
      got.position = rsp_ch.position;
      got.count    = rsp_ch.count;
      sb.check_response(got);
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = OP_INSERT;
    req_ch.key      = '0;
    req_ch.index    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Fill to the top and push inserts into the full list, then flip the order
    // with keys stored while the response side is held off, empty the list in
    // descending mode, refill with no idle cycles at all, and finish with
    // ascending drain and balanced traffic.
    run_traffic(ORDER_ASC, MIX_FILL, 85, 1'b0);
    run_traffic(ORDER_DESC, MIX_BALANCED, 90, 1'b1);
    run_traffic(ORDER_DESC, MIX_DRAIN, 90, 1'b0);
    quiet = 1'b1;
    run_traffic(ORDER_DESC, MIX_FILL, 85, 1'b0);
    quiet = 1'b0;
    run_traffic(ORDER_ASC, MIX_DRAIN, 90, 1'b0);
    run_traffic(ORDER_ASC, MIX_BALANCED, 90, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d responses never arrived", sb.outstanding());
      sb.errors++;
    end

    $display("Covered %0d inserts (%0d into a full list), %0d gets, %0d removes, %0d unused codes",
             sb.n_insert, sb.n_full, sb.n_get, sb.n_remove, sb.n_unused);
    $display("%0d out of range, peak fill %0d, %0d order writes, %0d long holds, %0d checked",
             sb.n_oob, sb.peak, sb.n_order_writes, rsp_holds_done, sb.checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as an error.
  initial begin
    #5_000_000;
    $error("timeout with %0d responses outstanding", sb.outstanding());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
